// ===== rtl/core/wss_pkg.sv =====
`timescale 1ns / 1ps
package wss_pkg;

   // Fraction width of the breakpoint and level registers.
   localparam int FRAC_BITS = 16;

   localparam int XW    = 26;   // x_max * 1000 in thousandths
   localparam int POSW  = 28;   // signed position and segment values
   localparam int MOVEW = 30;   // speed * delta_t
   localparam int SUMW  = 32;   // position before the end stops
   localparam int MULW  = 28;   // signed operands of the shared multiplier
   localparam int PRODW = 2 * MULW;
   localparam int DIVNW = 52;   // dividend magnitude
   localparam int DIVDW = 26;   // divisor
   localparam int DIVQW = 26;   // quotient bits, one per cycle
   localparam int OUTW  = 17;

   // Division by 1000 as a multiplication by ceil(2^36 / 1000); exact below 2^26.
   localparam int REC_SHIFT = 36;
   localparam logic [MULW-1:0] REC_MUL = 28'd68719477;
   localparam logic [9:0] MILLI = 10'd1000;

   typedef enum logic [1:0] {
      REQ_TICK = 2'd0,
      REQ_INC  = 2'd1,
      REQ_DEC  = 2'd2,
      REQ_NONE = 2'd3
   } req_kind_type;

   localparam logic [2:0] CSR_X_MAX      = 3'd0;
   localparam logic [2:0] CSR_BP_X1      = 3'd1;
   localparam logic [2:0] CSR_BP_Y1      = 3'd2;
   localparam logic [2:0] CSR_BP_X2      = 3'd3;
   localparam logic [2:0] CSR_BP_Y2      = 3'd4;
   localparam logic [2:0] CSR_SPEED_STEP = 3'd5;
   localparam logic [2:0] CSR_SPEED_MAX  = 3'd6;

   typedef struct packed {
      logic [15:0] x_max;
      logic [15:0] bp_x1;
      logic [15:0] bp_y1;
      logic [15:0] bp_x2;
      logic [15:0] bp_y2;
      logic [19:0] speed_step;
      logic [19:0] speed_max;
   } cfg_type;

   localparam cfg_type CFG_RST = '{
      x_max:      16'd10000,
      bp_x1:      16'd6554,
      bp_y1:      16'd1638,
      bp_x2:      16'd45875,
      bp_y2:      16'd63898,
      speed_step: 20'd1000,
      speed_max:  20'd50000
   };

   localparam logic signed [POSW-1:0] POS_RST  = 28'sd10000000;
   localparam logic signed [OUTW-1:0] LAST_RST = 17'sd10000;

   typedef struct packed {
      logic signed [OUTW-1:0] pos;
      logic                   flag;
   } res_type;

   typedef struct packed {
      logic signed [MULW-1:0] a;
      logic signed [MULW-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic             start;
      logic [DIVNW-1:0] dividend;
      logic [DIVDW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIVQW-1:0] quot;
   } div_rsp_type;

endpackage

// ===== rtl/core/wss_mul.sv =====
`timescale 1ns / 1ps
module wss_mul (
   input  logic                               clock,
   input  wss_pkg::mul_req_type               mul_req,
   output logic signed [wss_pkg::PRODW-1:0]   prod
);
   import wss_pkg::*;

   logic signed [MULW-1:0]  a_s;
   logic signed [MULW-1:0]  b_s;
   logic signed [PRODW-1:0] prod_in;
   logic signed [PRODW-1:0] prod_ff;

   assign a_s     = mul_req.a;
   assign b_s     = mul_req.b;
   assign prod_in = a_s * b_s;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/core/wss_div.sv =====
`timescale 1ns / 1ps
module wss_div (
   input  logic                  clock,
   input  logic                  reset,
   input  wss_pkg::div_req_type  div_req,
   output wss_pkg::div_rsp_type  div_rsp
);
   import wss_pkg::*;

   localparam int CNTW = $clog2(DIVQW + 1);

   typedef enum logic {DIV_IDLE, DIV_RUN} div_state_type;

   div_state_type     state_ff;
   logic [DIVDW-1:0]  rem_ff;
   logic [DIVQW-1:0]  num_ff;
   logic [DIVDW-1:0]  den_ff;
   logic [CNTW-1:0]   cnt_ff;
   logic              done_ff;

   logic [DIVDW:0]    trial;
   logic              ge;
   logic [DIVDW:0]    diff;
   logic [DIVDW-1:0]  rem_in;
   logic [DIVQW-1:0]  num_in;

   // Restoring division: the partial remainder stays below the divisor,
   // so one trial subtract per cycle yields one quotient bit.
   assign trial  = {rem_ff, num_ff[DIVQW-1]};
   assign ge     = trial >= {1'b0, den_ff};
   assign diff   = trial - {1'b0, den_ff};
   assign rem_in = ge ? diff[DIVDW-1:0] : trial[DIVDW-1:0];
   assign num_in = {num_ff[DIVQW-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         case (state_ff)
            DIV_IDLE: begin
               done_ff <= 1'b0;
               if (div_req.start) begin
                  rem_ff   <= div_req.dividend[DIVNW-1:DIVQW];
                  num_ff   <= div_req.dividend[DIVQW-1:0];
                  den_ff   <= div_req.divisor;
                  cnt_ff   <= CNTW'(DIVQW);
                  state_ff <= DIV_RUN;
               end
            end
            DIV_RUN: begin
               rem_ff  <= rem_in;
               num_ff  <= num_in;
               cnt_ff  <= cnt_ff - CNTW'(1);
               done_ff <= (cnt_ff == CNTW'(1));
               if (cnt_ff == CNTW'(1)) begin
                  state_ff <= DIV_IDLE;
               end
            end
            default: begin
               done_ff  <= 1'b0;
               state_ff <= DIV_IDLE;
            end
         endcase
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = num_ff;

endmodule

// ===== rtl/core/wss_core.sv =====
`timescale 1ns / 1ps
module wss_core (
   input  logic              clock,
   input  logic              reset,
   input  wss_pkg::cfg_type  cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [1:0]        in_type,
   input  logic [9:0]        in_dt,
   output logic              res_valid,
   input  logic              res_ready,
   output wss_pkg::res_type  res
);
   import wss_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_MOVE, S_XMUL, S_POS, S_CLAMP, S_B1, S_L1, S_B2, S_L2,
      S_SEL, S_SEGMUL, S_DIVS, S_DIVW, S_REC, S_DEC, S_OUT
   } core_state_type;

   core_state_type           state_ff;
   logic [19:0]              speed_ff;
   logic signed [POSW-1:0]   pos_ff;
   logic                     up_ff;
   logic                     prev_ff;
   logic signed [OUTW-1:0]   last_ff;
   logic                     flag_ff;
   logic [9:0]               dt_ff;
   logic [MOVEW-1:0]         move_ff;
   logic [XW-1:0]            x_ff;
   logic signed [SUMW-1:0]   sum_ff;
   logic [XW-1:0]            b1_ff;
   logic [XW-1:0]            l1_ff;
   logic [XW-1:0]            b2_ff;
   logic [XW-1:0]            l2_ff;
   logic signed [POSW-1:0]   off_ff;
   logic signed [POSW-1:0]   rise_ff;
   logic signed [POSW-1:0]   run_ff;
   logic signed [POSW-1:0]   base_ff;
   logic                     skip_ff;
   logic                     neg_ff;
   logic signed [POSW-1:0]   y_ff;

   mul_req_type              mul_req;
   logic signed [PRODW-1:0]  mul_prod;
   div_req_type              div_req;
   div_rsp_type              div_rsp;

   logic [20:0]              inc_sum;
   logic [19:0]              speed_inc;
   logic [19:0]              speed_dec;
   logic signed [SUMW-1:0]   pos_ext;
   logic signed [SUMW-1:0]   move_ext;
   logic signed [SUMW-1:0]   x_ext;
   logic signed [SUMW-1:0]   sum_in;
   logic signed [POSW-1:0]   x_pos;
   logic signed [POSW-1:0]   pos_cl_in;
   logic                     up_in;
   logic [17:0]              x_tri;
   logic                     fast;
   logic [XW-1:0]            frac_in;
   logic signed [POSW-1:0]   b1_s;
   logic signed [POSW-1:0]   b2_s;
   logic signed [POSW-1:0]   l1_s;
   logic signed [POSW-1:0]   l2_s;
   logic signed [POSW-1:0]   off_in;
   logic signed [POSW-1:0]   rise_in;
   logic signed [POSW-1:0]   run_in;
   logic signed [POSW-1:0]   base_in;
   logic [PRODW-1:0]         prod_abs;
   logic signed [POSW-1:0]   q_ext;
   logic signed [POSW-1:0]   y_in;
   logic signed [POSW-1:0]   y_abs;
   logic [15:0]              q_dec;
   logic signed [OUTW-1:0]   q_out;
   logic signed [OUTW-1:0]   last_in;

   // A breakpoint taken as a fraction of the full range, held at the range.
   function automatic logic [XW-1:0] frac_cap(input logic signed [PRODW-1:0] p,
                                              input logic [XW-1:0] x);
      logic [PRODW-1:0] pu;
      logic [PRODW-1:0] sh;
      pu = p;
      sh = pu >> FRAC_BITS;
      if (sh > PRODW'(x)) begin
         return x;
      end
      return sh[XW-1:0];
   endfunction

   wss_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (mul_prod)
   );

   wss_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Speed events.
   assign inc_sum   = {1'b0, speed_ff} + {1'b0, cfg.speed_step};
   assign speed_inc = (inc_sum > {1'b0, cfg.speed_max}) ? cfg.speed_max : inc_sum[19:0];
   assign speed_dec = (cfg.speed_step >= speed_ff) ? 20'd0 : speed_ff - cfg.speed_step;

   // Position update and end stops.
   assign pos_ext  = pos_ff;
   assign move_ext = {{(SUMW-MOVEW){1'b0}}, move_ff};
   assign sum_in   = up_ff ? pos_ext + move_ext : pos_ext - move_ext;
   assign x_ext    = {{(SUMW-XW){1'b0}}, x_ff};
   assign x_pos    = {{(POSW-XW){1'b0}}, x_ff};

   always_comb begin
      pos_cl_in = sum_ff[POSW-1:0];
      up_in     = up_ff;
      if (sum_ff > x_ext) begin
         pos_cl_in = x_pos;
         up_in     = 1'b0;
      end else if (sum_ff < -x_ext) begin
         pos_cl_in = -x_pos;
         up_in     = 1'b1;
      end
   end

   assign x_tri = {2'b00, cfg.x_max} + {1'b0, cfg.x_max, 1'b0};
   assign fast  = {speed_ff, 1'b0} >= {3'b000, x_tri};

   assign frac_in = frac_cap(mul_prod, x_ff);

   // Segment selection of the odd-symmetric curve.
   assign b1_s = {{(POSW-XW){1'b0}}, b1_ff};
   assign b2_s = {{(POSW-XW){1'b0}}, b2_ff};
   assign l1_s = {{(POSW-XW){1'b0}}, l1_ff};
   assign l2_s = {{(POSW-XW){1'b0}}, l2_ff};

   always_comb begin
      if (pos_ff > b2_s) begin
         off_in  = pos_ff - b2_s;
         rise_in = x_pos - l2_s;
         run_in  = x_pos - b2_s;
         base_in = l2_s;
      end else if (pos_ff > b1_s) begin
         off_in  = pos_ff - b1_s;
         rise_in = l2_s - l1_s;
         run_in  = b2_s - b1_s;
         base_in = l1_s;
      end else if (pos_ff > -b1_s) begin
         off_in  = pos_ff;
         rise_in = l1_s;
         run_in  = b1_s;
         base_in = '0;
      end else if (pos_ff > -b2_s) begin
         off_in  = pos_ff + b1_s;
         rise_in = l2_s - l1_s;
         run_in  = b2_s - b1_s;
         base_in = -l1_s;
      end else begin
         off_in  = pos_ff + b2_s;
         rise_in = x_pos - l2_s;
         run_in  = x_pos - b2_s;
         base_in = -l2_s;
      end
   end

   assign prod_abs = mul_prod[PRODW-1] ? PRODW'(-mul_prod) : PRODW'(mul_prod);
   assign q_ext    = {{(POSW-DIVQW){1'b0}}, div_rsp.quot};
   assign y_in     = base_ff + (neg_ff ? -q_ext : q_ext);
   assign y_abs    = y_ff[POSW-1] ? -y_ff : y_ff;
   assign q_dec    = mul_prod[REC_SHIFT +: 16];
   assign q_out    = {1'b0, q_dec};
   assign last_in  = y_ff[POSW-1] ? -q_out : q_out;

   always_comb begin
      mul_req.a = '0;
      mul_req.b = '0;
      case (state_ff)
         S_MOVE: begin
            mul_req.a = MULW'(speed_ff);
            mul_req.b = MULW'(dt_ff);
         end
         S_XMUL: begin
            mul_req.a = MULW'(cfg.x_max);
            mul_req.b = MULW'(MILLI);
         end
         S_CLAMP: begin
            mul_req.a = MULW'(cfg.bp_x1);
            mul_req.b = MULW'(x_ff);
         end
         S_B1: begin
            mul_req.a = MULW'(cfg.bp_y1);
            mul_req.b = MULW'(x_ff);
         end
         S_L1: begin
            mul_req.a = MULW'(cfg.bp_x2);
            mul_req.b = MULW'(x_ff);
         end
         S_B2: begin
            mul_req.a = MULW'(cfg.bp_y2);
            mul_req.b = MULW'(x_ff);
         end
         S_SEGMUL: begin
            mul_req.a = rise_ff;
            mul_req.b = off_ff;
         end
         S_REC: begin
            mul_req.a = y_abs;
            mul_req.b = REC_MUL;
         end
         default: begin
            mul_req.a = '0;
            mul_req.b = '0;
         end
      endcase
   end

   assign div_req.start    = (state_ff == S_DIVS) && !skip_ff;
   assign div_req.dividend = prod_abs[DIVNW-1:0];
   assign div_req.divisor  = run_ff[DIVDW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         speed_ff <= '0;
         pos_ff   <= POS_RST;
         up_ff    <= 1'b0;
         prev_ff  <= 1'b0;
         last_ff  <= LAST_RST;
         flag_ff  <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (in_valid) begin
                  dt_ff   <= in_dt;
                  flag_ff <= 1'b0;
                  case (in_type)
                     REQ_TICK: state_ff <= S_MOVE;
                     REQ_INC: begin
                        speed_ff <= speed_inc;
                        state_ff <= S_OUT;
                     end
                     REQ_DEC: begin
                        speed_ff <= speed_dec;
                        state_ff <= S_OUT;
                     end
                     default: state_ff <= S_OUT;
                  endcase
               end
            end
            S_MOVE:  state_ff <= S_XMUL;
            S_XMUL: begin
               move_ff  <= mul_prod[MOVEW-1:0];
               state_ff <= S_POS;
            end
            S_POS: begin
               x_ff     <= mul_prod[XW-1:0];
               sum_ff   <= sum_in;
               state_ff <= S_CLAMP;
            end
            S_CLAMP: begin
               pos_ff   <= pos_cl_in;
               up_ff    <= up_in;
               prev_ff  <= up_in;
               flag_ff  <= (up_in != prev_ff) && fast;
               state_ff <= S_B1;
            end
            S_B1: begin
               b1_ff    <= frac_in;
               state_ff <= S_L1;
            end
            S_L1: begin
               l1_ff    <= frac_in;
               state_ff <= S_B2;
            end
            S_B2: begin
               b2_ff    <= frac_in;
               state_ff <= S_L2;
            end
            S_L2: begin
               l2_ff    <= frac_in;
               state_ff <= S_SEL;
            end
            S_SEL: begin
               off_ff   <= off_in;
               rise_ff  <= rise_in;
               run_ff   <= run_in;
               base_ff  <= base_in;
               // An empty or reversed segment gives its base level.
               skip_ff  <= run_in[POSW-1] || (run_in == '0);
               state_ff <= S_SEGMUL;
            end
            S_SEGMUL: state_ff <= S_DIVS;
            S_DIVS: begin
               neg_ff <= mul_prod[PRODW-1];
               if (skip_ff) begin
                  y_ff     <= base_ff;
                  state_ff <= S_REC;
               end else begin
                  state_ff <= S_DIVW;
               end
            end
            S_DIVW: begin
               if (div_rsp.done) begin
                  y_ff     <= y_in;
                  state_ff <= S_REC;
               end
            end
            S_REC:   state_ff <= S_DEC;
            S_DEC: begin
               last_ff  <= last_in;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (res_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign in_ready  = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_OUT);
   assign res.pos   = last_ff;
   assign res.flag  = flag_ff;

endmodule

// ===== rtl/core/wiper_sweep_shaper_top.sv =====
`timescale 1ns / 1ps
// Wiper sweep generator with a piecewise-linear output shaper.
// The req_ channel takes one word per event: a tick with its elapsed
// milliseconds, or a speed increase or decrease. Every accepted word gives
// exactly one word on the rsp_ channel with the shaped position and the
// sound flag; speed events repeat the last shaped position with the flag low.
// A tick runs these steps in order before its word is valid on rsp_: six
// passes through the shared 28 x 28 multiplier for the move, the range and
// the four breakpoints, one for the segment product, the bit-serial divider
// for the segment slope, then one more multiply that scales thousandths to
// units. A tick on an empty or reversed segment skips the divider. req_tready
// is high only while the sequencer is idle, in the cycle after its result
// leaves, so no new word is taken while one is in progress.
// The rsp_ side has its own output register: the next item is accepted while
// a result waits, and the sequencer holds its finished result while the
// receiver stalls. The csr_ port writes one register per cycle and must be
// used only while the block is idle; the block itself does not enforce this.
// Synchronous reset restores the registers to their defaults, the position
// to the upper end and speed to 0.
module wiper_sweep_shaper_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   input  logic [15:0] req_tdata,   // [9:0] delta_t, [15:10] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tuser,   // [0] sound_flag
   output logic [23:0] rsp_tdata,   // [16:0] shaped_position, [23:17] zero
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [19:0] csr_wdata
);
   import wss_pkg::*;

   cfg_type                 cfg_ff;
   logic                    rsp_valid_ff;
   logic signed [OUTW-1:0]  rsp_pos_ff;
   logic                    rsp_flag_ff;

   logic                    res_valid;
   logic                    res_ready;
   res_type                 res;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_X_MAX:      cfg_ff.x_max      <= csr_wdata[15:0];
            CSR_BP_X1:      cfg_ff.bp_x1      <= csr_wdata[15:0];
            CSR_BP_Y1:      cfg_ff.bp_y1      <= csr_wdata[15:0];
            CSR_BP_X2:      cfg_ff.bp_x2      <= csr_wdata[15:0];
            CSR_BP_Y2:      cfg_ff.bp_y2      <= csr_wdata[15:0];
            CSR_SPEED_STEP: cfg_ff.speed_step <= csr_wdata;
            CSR_SPEED_MAX:  cfg_ff.speed_max  <= csr_wdata;
            default: ;
         endcase
      end
   end

   wss_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_type   (req_tuser),
      .in_dt     (req_tdata[9:0]),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_pos_ff  <= res.pos;
         rsp_flag_ff <= res.flag;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_flag_ff;
   assign rsp_tdata  = {7'b0, rsp_pos_ff};

   // Once a word is taken, the sequencer is busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken again right after acceptance");

   // A result handed over from the sequencer must show up on the output.
   assert property (@(posedge clock) disable iff (reset)
      res_valid && res_ready |=> rsp_tvalid)
      else $error("result lost between sequencer and output register");

   // The sequencer never finishes while a stalled result still occupies the output.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && res_valid |=> res_valid)
      else $error("sequencer dropped a result during an output stall");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import wss_pkg::*;

   localparam int SETTLE_CYCLES  = 60;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;    // [1:0] req_type
   logic [15:0] req_tdata;    // [9:0] delta_t, [15:10] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic        rsp_tuser;    // [0] sound_flag
   logic [23:0] rsp_tdata;    // [16:0] shaped_position, [23:17] zero
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [19:0] csr_wdata;

   bit long_hold   = 1'b0;
   bit send_idling = 1'b1;
   bit rsp_idling  = 1'b1;
   int words_sent  = 0;

   always #10 clock = ~clock;

   wiper_sweep_shaper_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Tracks the sweep state and holds the shaped outputs still to come.
   class sweep_checker;
      cfg_type  regs;
      longint   speed;
      longint   pos_milli;
      bit       moving_up;
      bit       prev_up;
      longint   last_shaped;
      res_type  shaped_q[$];
      int       errors = 0;

      function void restore();
         regs        = CFG_RST;
         speed       = 0;
         pos_milli   = regs.x_max;
         pos_milli   = pos_milli * 1000;
         moving_up   = 1'b0;
         prev_up     = 1'b0;
         last_shaped = regs.x_max;
         shaped_q.delete();
      endfunction

      function void write_reg(logic [2:0] addr, logic [19:0] value);
         case (addr)
            CSR_X_MAX:      regs.x_max      = value[15:0];
            CSR_BP_X1:      regs.bp_x1      = value[15:0];
            CSR_BP_Y1:      regs.bp_y1      = value[15:0];
            CSR_BP_X2:      regs.bp_x2      = value[15:0];
            CSR_BP_Y2:      regs.bp_y2      = value[15:0];
            CSR_SPEED_STEP: regs.speed_step = value;
            CSR_SPEED_MAX:  regs.speed_max  = value;
            default: ;
         endcase
      endfunction

      // Breakpoint in thousandths; fractions at or above one act as one.
      function longint frac_of(logic [15:0] frac, longint full);
         longint v;
         v = frac;
         v = (v * full) >>> FRAC_BITS;
         if (v > full) v = full;
         return v;
      endfunction

      function longint segment(longint off, longint rise, longint run, longint base);
         if (run <= 0) return base;
         return base + (rise * off) / run;
      endfunction

      function longint shape_position(longint p);
         longint full, b1, l1, b2, l2, y;
         full = regs.x_max;
         full = full * 1000;
         b1   = frac_of(regs.bp_x1, full);
         l1   = frac_of(regs.bp_y1, full);
         b2   = frac_of(regs.bp_x2, full);
         l2   = frac_of(regs.bp_y2, full);
         if (p > b2)       y = segment(p - b2, full - l2, full - b2, l2);
         else if (p > b1)  y = segment(p - b1, l2 - l1, b2 - b1, l1);
         else if (p > -b1) y = segment(p, l1, b1, 0);
         else if (p > -b2) y = segment(p + b1, l2 - l1, b2 - b1, -l1);
         else              y = segment(p + b2, full - l2, full - b2, -l2);
         return y / 1000;
      endfunction

      function void note_word(req_kind_type kind, logic [9:0] dt);
         longint step, top_speed, xm, full, move;
         bit turned;
         res_type r;
         step      = regs.speed_step;
         top_speed = regs.speed_max;
         xm        = regs.x_max;
         full      = xm * 1000;
         r.flag    = 1'b0;
         case (kind)
            REQ_INC: speed = (speed + step > top_speed) ? top_speed : speed + step;
            REQ_DEC: speed = (step >= speed) ? 0 : speed - step;
            REQ_TICK: begin
               move = dt;
               move = move * speed;
               pos_milli += moving_up ? move : -move;
               if (pos_milli > full) begin
                  pos_milli = full;
                  moving_up = 1'b0;
               end else if (pos_milli < -full) begin
                  pos_milli = -full;
                  moving_up = 1'b1;
               end
               last_shaped = shape_position(pos_milli);
               turned      = (moving_up != prev_up);
               prev_up     = moving_up;
               if (turned && speed * 2 >= xm * 3) r.flag = 1'b1;
            end
            default: ;
         endcase
         r.pos = last_shaped[OUTW-1:0];
         shaped_q.push_back(r);
      endfunction

      task report_mismatch(string what);
         $display("%0t ns: MISMATCH %s", $time, what);
         errors++;
      endtask

      task check_word(logic signed [OUTW-1:0] pos, logic flag);
         res_type e;
         if (shaped_q.size() == 0) begin
            report_mismatch($sformatf("output word %0d/%0b with nothing expected", pos, flag));
            return;
         end
         e = shaped_q.pop_front();
         if (pos !== e.pos)
            report_mismatch($sformatf("shaped_position %0d, expected %0d", pos, e.pos));
         if (flag !== e.flag)
            report_mismatch($sformatf("sound_flag %0b, expected %0b", flag, e.flag));
      endtask
   endclass

   sweep_checker sweep;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sweep.check_word(rsp_tdata[OUTW-1:0], rsp_tuser);
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_tready = 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            long_hold = 1'b0;
         end else if (rsp_idling && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(0, 11)) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [9:0] pick_delta();
      case ($urandom_range(0, 7))
         0:       return 10'd0;
         1:       return 10'd1000;
         2:       return 10'($urandom_range(0, 15));
         default: return 10'($urandom_range(0, 1000));
      endcase
   endfunction

   task automatic send_word(req_kind_type kind, logic [9:0] dt);
      if (send_idling && $urandom_range(0, 4) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {6'd0, dt};
      do @(posedge clock); while (!req_tready);
      sweep.note_word(kind, dt);
      words_sent++;
      @(negedge clock);
   endtask

   // Waits until every expected word is out and the sequencer has settled.
   task automatic drain();
      req_tvalid = 1'b0;
      while (sweep.shaped_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] addr, logic [19:0] value);
      csr_we    = 1'b1;
      csr_addr  = addr;
      csr_wdata = value;
      @(negedge clock);
      sweep.write_reg(addr, value);
   endtask

   task automatic apply_config(logic [15:0] xm, logic [15:0] x1, logic [15:0] y1,
                               logic [15:0] x2, logic [15:0] y2,
                               logic [19:0] step, logic [19:0] top_speed);
      drain();
      write_reg(CSR_X_MAX, {4'd0, xm});
      write_reg(CSR_BP_X1, {4'd0, x1});
      write_reg(CSR_BP_Y1, {4'd0, y1});
      write_reg(CSR_BP_X2, {4'd0, x2});
      write_reg(CSR_BP_Y2, {4'd0, y2});
      write_reg(CSR_SPEED_STEP, step);
      write_reg(CSR_SPEED_MAX, top_speed);
      csr_we = 1'b0;
   endtask

   // Speed is scaled to x_max so that fast turns with a sound flag occur.
   task automatic random_config(bit ordered);
      int xm, x1, x2, top;
      xm  = $urandom_range(100, 40000);
      x1  = ordered ? $urandom_range(1, 32767) : $urandom_range(1, 65535);
      x2  = ordered ? $urandom_range(32768, 65535) : $urandom_range(1, 65535);
      top = $urandom_range(xm, 4 * xm);
      apply_config(16'(xm), 16'(x1), 16'($urandom_range(0, 65535)), 16'(x2),
                   16'($urandom_range(0, 65535)),
                   20'($urandom_range(xm / 10 + 1, xm / 2 + 1)), 20'(top));
   endtask

   // Mostly bursts of speed-ups and runs of ticks, some slow-downs, and some noise.
   task automatic run_random(int words);
      int stop_at, choice;
      req_kind_type kind;
      logic [9:0] dt;
      stop_at = words_sent + words;
      while (words_sent < stop_at) begin
         choice = $urandom_range(0, 9);
         if (choice < 3) begin
            repeat ($urandom_range(1, 20)) send_word(REQ_INC, 10'($urandom_range(0, 1023)));
         end else if (choice < 4) begin
            repeat ($urandom_range(1, 6)) send_word(REQ_DEC, 10'($urandom_range(0, 1023)));
         end else if (choice < 9) begin
            repeat ($urandom_range(1, 10)) send_word(REQ_TICK, pick_delta());
         end else begin
            kind = req_kind_type'($urandom_range(0, 3));
            dt   = (kind == REQ_TICK) ? pick_delta() : 10'($urandom_range(0, 1023));
            send_word(kind, dt);
         end
      end
   endtask

   initial begin
      sweep      = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = REQ_TICK;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = CSR_X_MAX;
      csr_wdata  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      sweep.restore();

      // Directed words at the reset settings: speed saturating at zero,
      // the unused request kind, then a fast sweep that turns at the low end.
      send_word(REQ_TICK, 10'd0);
      send_word(REQ_INC, 10'd1023);
      send_word(REQ_DEC, 10'd0);
      send_word(REQ_DEC, 10'd512);
      send_word(REQ_NONE, 10'd1023);
      repeat (16) send_word(REQ_INC, 10'd0);
      send_word(REQ_TICK, 10'd1000);
      send_word(REQ_TICK, 10'd1000);
      send_word(REQ_TICK, 10'd1);
      send_word(REQ_TICK, 10'd1000);

      // The receiver holds off while words keep coming, so the input stalls.
      long_hold = 1'b1;
      run_random(50);

      apply_config(16'd65535, 16'd1, 16'd0, 16'd65535, 16'd65535, 20'd1048575, 20'd1048575);
      run_random(55);

      // Much smaller x_max and speed limit: the old position and speed get clamped.
      apply_config(16'd1, 16'd65535, 16'd65535, 16'd1, 16'd0, 20'd0, 20'd0);
      run_random(40);

      apply_config(16'd1000, 16'd50000, 16'd40000, 16'd20000, 16'd60000, 20'd300, 20'd5000);
      run_random(60);

      apply_config(16'd3000, 16'd30000, 16'd0, 16'd30000, 16'd65535, 20'd100, 20'd20000);
      run_random(60);

      random_config(1'b1);
      run_random(65);
      random_config(1'b0);
      run_random(65);

      apply_config(CFG_RST.x_max, CFG_RST.bp_x1, CFG_RST.bp_y1, CFG_RST.bp_x2,
                   CFG_RST.bp_y2, CFG_RST.speed_step, CFG_RST.speed_max);
      send_idling = 1'b0;
      rsp_idling  = 1'b0;
      run_random(60);

      drain();
      if (sweep.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
